// ===== rtl/lwps_pkg.sv =====
// lwps_pkg: shared types and constants of the lcd window pixel stream
`timescale 1ns / 1ps
package lwps_pkg;

  localparam int unsigned LWPS_SCREEN_WIDTH  = 128;
  localparam int unsigned LWPS_SCREEN_HEIGHT = 160;
  localparam int unsigned LWPS_QUEUE_DEPTH   = 4;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  typedef enum logic [2:0] {
    MODE_FILL = 3'd0,
    MODE_RGB  = 3'd1,
    MODE_GRAY = 3'd2,
    MODE_BOOL = 3'd3,
    MODE_BITS = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_REGION_X      = 3'd0,
    REG_REGION_Y      = 3'd1,
    REG_REGION_WIDTH  = 3'd2,
    REG_REGION_HEIGHT = 3'd3,
    REG_SOURCE_MODE   = 3'd4,
    REG_COLOR_TRUE    = 3'd5,
    REG_COLOR_FALSE   = 3'd6,
    REG_PX_LIMIT      = 3'd7
  } reg_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef struct packed {
    logic [6:0]  region_x;
    logic [7:0]  region_y;
    logic [7:0]  region_width;
    logic [7:0]  region_height;
    logic [2:0]  source_mode;
    logic [15:0] color_true;
    logic [15:0] color_false;
    logic [14:0] px_limit;
  } cfg_t;

  // one queue entry: a window header or one pixel to send
  typedef struct packed {
    kind_e       kind;
    logic        last;
    logic [15:0] color;
    logic [6:0]  x;
    logic [7:0]  y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
  } entry_t;

  // start byte positions
  typedef enum logic [3:0] {
    SB_CASET    = 4'd0,
    SB_XS_HI    = 4'd1,
    SB_XS_LO    = 4'd2,
    SB_XE_HI    = 4'd3,
    SB_XE_LO    = 4'd4,
    SB_RASET    = 4'd5,
    SB_YS_HI    = 4'd6,
    SB_YS_LO    = 4'd7,
    SB_YE_HI    = 4'd8,
    SB_YE_LO    = 4'd9,
    SB_RAMWR    = 4'd10
  } start_byte_e;

endpackage

// ===== rtl/lwps_regs.sv =====
// lwps_regs: apb configuration registers
`timescale 1ns / 1ps
module lwps_regs import lwps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_REGION_X:      cfg_d.region_x      = pwdata[6:0];
        REG_REGION_Y:      cfg_d.region_y      = pwdata[7:0];
        REG_REGION_WIDTH:  cfg_d.region_width  = pwdata[7:0];
        REG_REGION_HEIGHT: cfg_d.region_height = pwdata[7:0];
        REG_SOURCE_MODE:   cfg_d.source_mode   = pwdata[2:0];
        REG_COLOR_TRUE:    cfg_d.color_true    = pwdata[15:0];
        REG_COLOR_FALSE:   cfg_d.color_false   = pwdata[15:0];
        REG_PX_LIMIT:      cfg_d.px_limit      = pwdata[14:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REGION_X:      prdata = {25'd0, cfg_q.region_x};
      REG_REGION_Y:      prdata = {24'd0, cfg_q.region_y};
      REG_REGION_WIDTH:  prdata = {24'd0, cfg_q.region_width};
      REG_REGION_HEIGHT: prdata = {24'd0, cfg_q.region_height};
      REG_SOURCE_MODE:   prdata = {29'd0, cfg_q.source_mode};
      REG_COLOR_TRUE:    prdata = {16'd0, cfg_q.color_true};
      REG_COLOR_FALSE:   prdata = {16'd0, cfg_q.color_false};
      REG_PX_LIMIT:      prdata = {17'd0, cfg_q.px_limit};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_x      <= 7'd0;
      cfg_q.region_y      <= 8'd0;
      cfg_q.region_width  <= 8'd128;
      cfg_q.region_height <= 8'd160;
      cfg_q.source_mode   <= 3'd0;
      cfg_q.color_true    <= 16'd0;
      cfg_q.color_false   <= 16'd0;
      cfg_q.px_limit      <= 15'd20480;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lwps_front.sv =====
// lwps_front: accepts items, clips the window and walks source pixels
`timescale 1ns / 1ps
module lwps_front import lwps_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = LWPS_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = LWPS_SCREEN_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] pixel_value_i,
  input  logic        q_full_i,
  output logic        push_o,
  output entry_t      push_data_o
);

  localparam logic [8:0] SW = 9'(SCREEN_WIDTH);
  localparam logic [8:0] SH = 9'(SCREEN_HEIGHT);

  // held item
  logic        item_valid_q;
  logic        item_action_q;
  logic [15:0] item_pv_q;
  logic [3:0]  bit_q, bit_d;
  logic        pend_valid_q, pend_valid_d;
  logic [15:0] pend_color_q, pend_color_d;

  // stream state
  logic [7:0]  cw_q, cw_d, ch_q, ch_d;
  logic [7:0]  col_q, col_d, row_q, row_d;
  logic [14:0] src_q, src_d;
  logic        phase_q, phase_d;

  logic        done;
  logic        accept;
  logic        advance;
  mode_e       mode;
  logic        is_bits, flush, valid_mode, check_count, in_window, emit_px;
  logic        cur_bit;
  logic [7:0]  gray;
  logic [15:0] color;
  logic [8:0]  room_x, room_y;
  logic [7:0]  clip_w, clip_h;
  logic [7:0]  col_inc;

  assign mode    = mode_e'(cfg_i.source_mode);
  assign is_bits = (mode == MODE_BITS);
  assign flush   = is_bits && (bit_q == 4'd8);
  assign cur_bit = item_pv_q[3'd7 - bit_q[2:0]];
  assign gray    = item_pv_q[7:0];

  always_comb begin
    valid_mode  = 1'b1;
    check_count = 1'b1;
    case (mode)
      MODE_FILL: begin
        color       = cfg_i.color_true;
        check_count = 1'b0;
      end
      MODE_RGB:  color = item_pv_q;
      MODE_GRAY: color = {gray[7:3], gray[7:2], gray[7:3]};
      MODE_BOOL: color = item_pv_q[0] ? cfg_i.color_true : cfg_i.color_false;
      MODE_BITS: color = cur_bit ? cfg_i.color_true : cfg_i.color_false;
      default: begin
        color       = 16'd0;
        valid_mode  = 1'b0;
        check_count = 1'b0;
      end
    endcase
  end

  assign in_window = (col_q < cw_q) && (row_q < ch_q) &&
                     (!check_count || (src_q < cfg_i.px_limit));
  assign emit_px   = valid_mode && in_window;

  // window clipping
  assign room_x = SW - {2'b00, cfg_i.region_x};
  assign room_y = SH - {1'b0, cfg_i.region_y};
  always_comb begin
    if ({2'b00, cfg_i.region_x} >= SW) begin
      clip_w = 8'd0;
    end else if ({1'b0, cfg_i.region_width} < room_x) begin
      clip_w = cfg_i.region_width;
    end else begin
      clip_w = room_x[7:0];
    end
    if ({1'b0, cfg_i.region_y} >= SH) begin
      clip_h = 8'd0;
    end else if ({1'b0, cfg_i.region_height} < room_y) begin
      clip_h = cfg_i.region_height;
    end else begin
      clip_h = room_y[7:0];
    end
  end

  always_comb begin
    done         = 1'b0;
    advance      = 1'b0;
    push_o       = 1'b0;
    push_data_o  = '0;
    bit_d        = bit_q;
    pend_valid_d = pend_valid_q;
    pend_color_d = pend_color_q;
    cw_d         = cw_q;
    ch_d         = ch_q;
    phase_d      = phase_q;
    if (item_valid_q) begin
      if (!item_action_q) begin
        push_o            = !q_full_i;
        push_data_o.kind  = KIND_START;
        push_data_o.last  = 1'b1;
        push_data_o.x     = cfg_i.region_x;
        push_data_o.y     = cfg_i.region_y;
        push_data_o.end_x = 8'({1'b0, cfg_i.region_x} + cfg_i.region_width - 8'd1);
        push_data_o.end_y = cfg_i.region_y + cfg_i.region_height - 8'd1;
        done              = !q_full_i;
        if (!q_full_i) begin
          cw_d    = clip_w;
          ch_d    = clip_h;
          phase_d = 1'b1;
        end
      end else if (!phase_q) begin
        done = 1'b1;
      end else if (!is_bits) begin
        push_data_o.kind  = KIND_PIXEL;
        push_data_o.last  = 1'b1;
        push_data_o.color = color;
        done              = !emit_px || !q_full_i;
        push_o            = emit_px && !q_full_i;
        advance           = done;
      end else if (!flush) begin
        push_data_o.kind  = KIND_PIXEL;
        push_data_o.last  = 1'b0;
        push_data_o.color = pend_color_q;
        if (!(emit_px && pend_valid_q) || !q_full_i) begin
          push_o  = emit_px && pend_valid_q;
          advance = 1'b1;
          bit_d   = bit_q + 4'd1;
          if (emit_px) begin
            pend_valid_d = 1'b1;
            pend_color_d = color;
          end
        end
      end else begin
        push_data_o.kind  = KIND_PIXEL;
        push_data_o.last  = 1'b1;
        push_data_o.color = pend_color_q;
        if (!pend_valid_q || !q_full_i) begin
          push_o       = pend_valid_q;
          pend_valid_d = 1'b0;
          bit_d        = 4'd0;
          done         = 1'b1;
        end
      end
    end
  end

  // counter walk for one source pixel position
  assign col_inc = col_q + 8'd1;
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    src_d = src_q;
    if (item_valid_q && !item_action_q && !q_full_i) begin
      col_d = 8'd0;
      row_d = 8'd0;
      src_d = 15'd0;
    end else if (advance) begin
      if (src_q != 15'h7FFF) begin
        src_d = src_q + 15'd1;
      end
      if (col_inc >= cfg_i.region_width) begin
        col_d = 8'd0;
        if (row_q != 8'hFF) begin
          row_d = row_q + 8'd1;
        end
      end else begin
        col_d = col_inc;
      end
    end
  end

  assign in_stall_o = item_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      bit_q        <= 4'd0;
      pend_valid_q <= 1'b0;
      cw_q         <= 8'd0;
      ch_q         <= 8'd0;
      col_q        <= 8'd0;
      row_q        <= 8'd0;
      src_q        <= 15'd0;
      phase_q      <= 1'b0;
    end else begin
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (done) begin
        item_valid_q <= 1'b0;
      end
      bit_q        <= bit_d;
      pend_valid_q <= pend_valid_d;
      cw_q         <= cw_d;
      ch_q         <= ch_d;
      col_q        <= col_d;
      row_q        <= row_d;
      src_q        <= src_d;
      phase_q      <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_color_q <= pend_color_d;
    if (accept) begin
      item_action_q <= action_i;
      item_pv_q     <= pixel_value_i;
    end
  end

endmodule

// ===== rtl/lwps_queue.sv =====
// lwps_queue: short entry queue between front and back
`timescale 1ns / 1ps
module lwps_queue import lwps_pkg::*; #(
  parameter int unsigned DEPTH = LWPS_QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/lwps_back.sv =====
// lwps_back: turns queue entries into the output byte stream
`timescale 1ns / 1ps
module lwps_back import lwps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  entry_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_command_o,
  output logic       last_o
);

  logic [3:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       cmd_q, cmd_d;
  logic       last_q, last_d;
  logic       load, final_byte;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    cmd_d      = 1'b0;
    byte_d     = 8'd0;
    final_byte = 1'b0;
    if (head_i.kind == KIND_START) begin
      case (start_byte_e'(idx_q))
        SB_CASET: begin
          byte_d = CMD_COLUMN_SET;
          cmd_d  = 1'b1;
        end
        SB_XS_LO: byte_d = {1'b0, head_i.x};
        SB_XE_LO: byte_d = head_i.end_x;
        SB_RASET: begin
          byte_d = CMD_ROW_SET;
          cmd_d  = 1'b1;
        end
        SB_YS_LO: byte_d = head_i.y;
        SB_YE_LO: byte_d = head_i.end_y;
        SB_RAMWR: begin
          byte_d     = CMD_MEMORY_WRITE;
          cmd_d      = 1'b1;
          final_byte = 1'b1;
        end
        default: byte_d = 8'd0;
      endcase
    end else begin
      byte_d     = idx_q[0] ? head_i.color[7:0] : head_i.color[15:8];
      final_byte = idx_q[0];
    end
    last_d = final_byte && head_i.last;
  end

  assign pop_o = load && !empty_i && final_byte;
  assign idx_d = final_byte ? 4'd0 : idx_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 4'd0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      cmd_q  <= cmd_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign is_command_o = cmd_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/lcd_window_pixel_stream.sv =====
// lcd_window_pixel_stream: top level of the panel window write byte stream
//
// input channel: in_valid_i / in_stall_o carry action_i and pixel_value_i;
// action 0 starts a window write, action 1 carries source pixel data
// output channel: out_valid_o / out_stall_i carry out_byte_o, is_command_o
// and last_o, one byte per transfer, last marking the final byte of an item
// a start item gives eleven bytes, a pixel two, a bit-mode item up to sixteen
// the first byte of an item passes the held item register, the queue and
// the output byte register before it can transfer at the output
// the output gives one byte per cycle while the queue holds bytes and the
// receiver does not stall; the front walks a bit-mode item one bit at a time
// the front walker and the byte sequencer are joined by a short queue, so
// the input keeps taking items while the sequencer drains earlier ones
// configuration over apb, registers at byte address 4*index, no wait states
// reset clears the stream state and sets the registers to their defaults;
// data items before the first start item are dropped
// when the receiver stalls the output byte holds and the queue fills, after
// which in_stall_o rises
`timescale 1ns / 1ps
module lcd_window_pixel_stream import lwps_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = LWPS_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = LWPS_SCREEN_HEIGHT,
  parameter int unsigned QUEUE_DEPTH   = LWPS_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [15:0]       pixel_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              is_command_o,
  output logic              last_o
);

  cfg_t   cfg;
  logic   push, pop, q_full, q_empty;
  entry_t push_data, head;

  lwps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lwps_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pixel_value_i (pixel_value_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  lwps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  lwps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_command_o (is_command_o),
    .last_o       (last_o)
  );

endmodule

// ===== bench/lcd_window_pixel_stream_tb.sv =====
// lcd_window_pixel_stream_tb: self-checking bench for the panel window write byte stream
`timescale 1ns / 1ps
module lcd_window_pixel_stream_tb;
  import lwps_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int DRAIN_CYCLES  = 64;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 470;
  localparam int MAX_REPORTS   = 10;
  localparam int SAT_INDEX     = 32767;
  localparam int SAT_ROW       = 255;

  localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       last;
  } panel_byte_t;

  class panel_byte_board;
    bit [6:0]  win_x;
    bit [7:0]  win_y;
    bit [7:0]  win_w;
    bit [7:0]  win_h;
    bit [2:0]  mode;
    bit [15:0] color_on;
    bit [15:0] color_off;
    bit [14:0] count;
    int        clip_w;
    int        clip_h;
    int        col;
    int        row;
    int        src_idx;
    bit        streaming;
    int        errors;
    panel_byte_t pending_bytes[$];

    function new();
      win_x     = 0;
      win_y     = 0;
      win_w     = 128;
      win_h     = 160;
      mode      = MODE_FILL;
      color_on  = 0;
      color_off = 0;
      count     = 20480;
      clip_w    = 0;
      clip_h    = 0;
      col       = 0;
      row       = 0;
      src_idx   = 0;
      streaming = 0;
      errors    = 0;
    endfunction

    function void write_reg(reg_e r, logic [31:0] v);
      case (r)
        REG_REGION_X:      win_x = v[6:0];
        REG_REGION_Y:      win_y = v[7:0];
        REG_REGION_WIDTH:  win_w = v[7:0];
        REG_REGION_HEIGHT: win_h = v[7:0];
        REG_SOURCE_MODE:   mode = v[2:0];
        REG_COLOR_TRUE:    color_on = v[15:0];
        REG_COLOR_FALSE:   color_off = v[15:0];
        REG_PX_LIMIT:      count = v[14:0];
        default: ;
      endcase
    endfunction

    function int clip_span(int pos, int span, int screen);
      if (pos >= screen) return 0;
      return (span < screen - pos) ? span : screen - pos;
    endfunction

    function void push_byte(logic [7:0] d, logic c);
      pending_bytes.push_back('{data: d, cmd: c, last: 1'b0});
    endfunction

    function void put_pixel(logic [15:0] color, bit use_count, bit shown);
      bit in_window;
      in_window = col < clip_w && row < clip_h && (!use_count || src_idx < count);
      if (shown && in_window) begin
        push_byte(color[15:8], 1'b0);
        push_byte(color[7:0], 1'b0);
      end
      if (src_idx < SAT_INDEX) src_idx++;
      col++;
      if (col >= win_w) begin
        col = 0;
        if (row < SAT_ROW) row++;
      end
    endfunction

    function void predict_item(logic act, logic [15:0] pv);
      int queued;
      int end_x;
      int end_y;
      logic [7:0] g;
      queued = pending_bytes.size();
      g = pv[7:0];
      if (act == KIND_START) begin
        clip_w    = clip_span(win_x, win_w, LWPS_SCREEN_WIDTH);
        clip_h    = clip_span(win_y, win_h, LWPS_SCREEN_HEIGHT);
        col       = 0;
        row       = 0;
        src_idx   = 0;
        streaming = 1;
        end_x     = win_x + win_w - 1;
        end_y     = win_y + win_h - 1;
        push_byte(CMD_COLUMN_SET, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte({1'b0, win_x}, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(end_x[7:0], 1'b0);
        push_byte(CMD_ROW_SET, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(win_y, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(end_y[7:0], 1'b0);
        push_byte(CMD_MEMORY_WRITE, 1'b1);
      end else if (streaming) begin
        case (mode)
          MODE_FILL: put_pixel(color_on, 1'b0, 1'b1);
          MODE_RGB:  put_pixel(pv, 1'b1, 1'b1);
          MODE_GRAY: put_pixel({g[7:3], g[7:2], g[7:3]}, 1'b1, 1'b1);
          MODE_BOOL: put_pixel(pv[0] ? color_on : color_off, 1'b1, 1'b1);
          MODE_BITS: begin
            for (int i = 7; i >= 0; i--)
              put_pixel(pv[i] ? color_on : color_off, 1'b1, 1'b1);
          end
          default: put_pixel(16'h0000, 1'b0, 1'b0);
        endcase
      end
      if (pending_bytes.size() > queued)
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(logic [7:0] d, logic c, logic l);
      panel_byte_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected output byte %02h cmd %0b last %0b at %0t",
                   d, c, l, $realtime);
      end else begin
        want = pending_bytes.pop_front();
        if (want.data !== d || want.cmd !== c || want.last !== l) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"byte mismatch at %0t: expected %02h cmd %0b last %0b, ",
                      "got %02h cmd %0b last %0b"},
                     $realtime, want.data, want.cmd, want.last, d, c, l);
        end
      end
    endfunction

    function void close_out();
      if (pending_bytes.size() != 0) begin
        errors += pending_bytes.size();
        $display("%0d expected output bytes never arrived", pending_bytes.size());
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              action_i      = 1'b0;
  logic [15:0]       pixel_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [7:0]        out_byte_o;
  logic              is_command_o;
  logic              last_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  panel_byte_board board = new();

  lcd_window_pixel_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_command_o  (is_command_o),
    .last_o        (last_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_byte(out_byte_o, is_command_o, last_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(logic act, logic [15:0] pv);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    pixel_value_i <= pv;
    do @(posedge clk_i); while (in_stall_o);
    board.predict_item(act, pv);
    items_sent++;
  endtask

  // stop sending and let the stream run dry before touching registers
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(r, v);
  endtask

  task automatic configure(logic [6:0] x, logic [7:0] y, logic [7:0] w, logic [7:0] h,
                           logic [2:0] m, logic [15:0] ct, logic [15:0] cf, logic [14:0] cnt);
    apb_write(REG_REGION_X, 32'(x));
    apb_write(REG_REGION_Y, 32'(y));
    apb_write(REG_REGION_WIDTH, 32'(w));
    apb_write(REG_REGION_HEIGHT, 32'(h));
    apb_write(REG_SOURCE_MODE, 32'(m));
    apb_write(REG_COLOR_TRUE, 32'(ct));
    apb_write(REG_COLOR_FALSE, 32'(cf));
    apb_write(REG_PX_LIMIT, 32'(cnt));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_window();
    logic [6:0]  x;
    logic [7:0]  y;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [2:0]  m;
    logic [14:0] cnt;
    int          n_data;
    int          noise_at;
    int          pick;
    pick = $urandom_range(99);
    x = (pick < 10) ? 7'd127 : (pick < 25) ? 7'($urandom_range(120, 127))
                                           : 7'($urandom_range(127));
    pick = $urandom_range(99);
    y = (pick < 10) ? 8'($urandom_range(160, 255)) : (pick < 20) ? 8'd159
                                                   : 8'($urandom_range(159));
    pick = $urandom_range(99);
    w = (pick < 5) ? 8'd0 : (pick < 10) ? 8'd255 : (pick < 15) ? 8'd128
                                                 : 8'($urandom_range(1, 12));
    pick = $urandom_range(99);
    h = (pick < 5) ? 8'd0 : (pick < 10) ? 8'd255 : (pick < 15) ? 8'd160
                                                 : 8'($urandom_range(1, 6));
    m = ($urandom_range(99) < 10) ? 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI))
                                  : 3'($urandom_range(MODE_FILL, MODE_BITS));
    pick = $urandom_range(99);
    cnt = (pick < 10) ? 15'd32767 : (pick < 20) ? 15'd0 : 15'($urandom_range(60));
    settle();
    configure(x, y, w, h, m, 16'($urandom), 16'($urandom), cnt);
    // mostly a fresh start; sometimes carry on with the new settings live
    if ($urandom_range(9) != 0) send_item(KIND_START, 16'($urandom));
    n_data   = $urandom_range(4, 24);
    noise_at = ($urandom_range(9) == 0) ? $urandom_range(n_data - 1) : -1;
    for (int i = 0; i < n_data; i++) begin
      if (i == noise_at) send_item(KIND_START, 16'($urandom));
      send_item(KIND_PIXEL, 16'($urandom));
    end
  endtask

  initial begin
    int target;
    send_idle_pct  = 12;
    recv_stall_pct = 63;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // pixel data before any start is dropped
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_START, 16'h0000);
    send_item(KIND_PIXEL, 16'h1234);

    // corner window, clipped to one pixel, end bytes point past the screen
    settle();
    configure(7'd127, 8'd159, 8'd2, 8'd3, MODE_RGB, 16'h0000, 16'h0000, 15'd3);
    send_item(KIND_START, 16'hFFFF);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_PIXEL, 16'h0000);
    send_item(KIND_PIXEL, 16'hA5A5);

    // gray, then window width dropped to zero mid-window
    settle();
    configure(7'd0, 8'd0, 8'd4, 8'd3, MODE_GRAY, 16'h0000, 16'h0000, 15'd32767);
    send_item(KIND_START, 16'h0000);
    send_item(KIND_PIXEL, 16'h00FF);
    send_item(KIND_PIXEL, 16'h0000);
    settle();
    configure(7'd0, 8'd0, 8'd0, 8'd3, MODE_GRAY, 16'h0000, 16'h0000, 15'd32767);
    send_item(KIND_PIXEL, 16'h1234);
    send_item(KIND_PIXEL, 16'h0080);
    send_item(KIND_PIXEL, 16'hFF55);

    // bool pixels cut off by the pixel count
    settle();
    configure(7'd3, 8'd2, 8'd4, 8'd2, MODE_BOOL, 16'hF800, 16'h001F, 15'd4);
    send_item(KIND_START, 16'h0000);
    send_item(KIND_PIXEL, 16'h0001);
    send_item(KIND_PIXEL, 16'h0000);
    send_item(KIND_PIXEL, 16'hFFFE);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_PIXEL, 16'h0001);

    // packed bits, window clipped at the right edge
    settle();
    configure(7'd120, 8'd150, 8'd10, 8'd2, MODE_BITS, 16'hFFFF, 16'h0000, 15'd12);
    send_item(KIND_START, 16'h0000);
    send_item(KIND_PIXEL, 16'h00A5);
    send_item(KIND_PIXEL, 16'hFF5A);
    send_item(KIND_PIXEL, 16'h0000);

    // undefined modes consume a position and send nothing
    settle();
    configure(7'd120, 8'd150, 8'd10, 8'd2, MODE_UNDEF_LO, 16'hFFFF, 16'h0000, 15'd12);
    send_item(KIND_PIXEL, 16'hFFFF);
    settle();
    configure(7'd120, 8'd150, 8'd10, 8'd2, MODE_UNDEF_HI, 16'hFFFF, 16'h0000, 15'd12);
    send_item(KIND_PIXEL, 16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 12 : (phase == 1) ? 63 : 0;
      recv_stall_pct = (phase == 0) ? 63 : (phase == 1) ? 12 : 0;
      target = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < target) random_window();
    end

    settle();
    board.close_out();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
